// File: rtl/core/ssd_pkg.sv
// Package for the seven-segment speed display: payload words, command codes,
// queue entry layout, divider constants and the segment decode table.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ssd_pkg;

    // Digit count and derived widths
    localparam int unsigned NUM_DIGITS  = 4;
    localparam int unsigned IDX_W       = $clog2(NUM_DIGITS);
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Digit codes
    localparam logic [3:0] BLANK_CODE = 4'hF;
    localparam logic [3:0] ZERO_CODE  = 4'h0;

    // Command codes; the fourth code is unused and ignored
    typedef enum logic [1:0] {
        CMD_LOAD  = 2'd0,
        CMD_CLEAR = 2'd1,
        CMD_SCAN  = 2'd2
    } t_cmd;

    // Input and result words
    typedef struct packed {
        logic [1:0]  command;
        logic [15:0] speed_tenths;
    } t_in_word;

    typedef struct packed {
        logic [6:0] segment_pattern;
        logic [3:0] digit_select_n;
        logic       decimal_point;
        logic [1:0] digit_index;
    } t_out_word;

    // Classified word passed from the front to the back
    typedef struct packed {
        t_cmd                             op;
        logic [NUM_DIGITS-1:0][3:0]       digits;
    } t_queue_entry;

    // Reciprocal constants: v / 10^i == (v * DIV_MULT[i]) >> DIV_SHIFT[i]
    // for every 16-bit v; powers beyond 10^4 exceed the range and give zero.
    localparam int unsigned DIV_MAX = 9;
    localparam int unsigned DIV_MULT [DIV_MAX] =
        '{1, 104858, 83887, 67109, 107375, 0, 0, 0, 0};
    localparam int unsigned DIV_SHIFT [DIV_MAX] =
        '{0, 20, 23, 26, 30, 0, 0, 0, 0};

    // Segment patterns gfedcba for numerals 0 to 9
    localparam logic [6:0] SEG_TABLE [10] = '{
        7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66,
        7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F
    };

endpackage

`default_nettype wire

// File: rtl/core/ssd_front.sv
// Front end: accepts input words, drops the unused command and splits a
// loaded speed into blanked decimal digits. Depends on ssd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ssd_front (
    input  wire ssd_pkg::t_in_word     i_word,
    output ssd_pkg::t_queue_entry      o_entry,
    output logic                       o_push_ok
);

    logic [ssd_pkg::NUM_DIGITS:0][16:0]     quot;
    logic [ssd_pkg::NUM_DIGITS-1:0][3:0]    digits;
    logic [32:0]                            prod;
    logic [16:0]                            tens;
    logic                                   leading;

    // Split into digits: quotients by reciprocal multiply, then remainders
    always_comb begin
        prod    = '0;
        tens    = '0;
        leading = 1'b1;
        for (int i = 0; i <= ssd_pkg::NUM_DIGITS; i++) begin
            prod    = 33'(i_word.speed_tenths) * 33'(ssd_pkg::DIV_MULT[i]);
            quot[i] = 17'(prod >> ssd_pkg::DIV_SHIFT[i]);
        end
        for (int i = 0; i < ssd_pkg::NUM_DIGITS; i++) begin
            tens      = (quot[i+1] << 3) + (quot[i+1] << 1);
            digits[i] = 4'(quot[i] - tens);
        end
        // Blank leading zeros from the top down to digit 2
        for (int i = ssd_pkg::NUM_DIGITS - 1; i >= 2; i--) begin
            if (leading && digits[i] == ssd_pkg::ZERO_CODE) begin
                digits[i] = ssd_pkg::BLANK_CODE;
            end else begin
                leading = 1'b0;
            end
        end
    end

    // Classify the command; the unused code is not queued
    always_comb begin
        o_entry.digits = digits;
        o_push_ok      = 1'b1;
        unique case (i_word.command)
            ssd_pkg::CMD_LOAD:  o_entry.op = ssd_pkg::CMD_LOAD;
            ssd_pkg::CMD_CLEAR: o_entry.op = ssd_pkg::CMD_CLEAR;
            ssd_pkg::CMD_SCAN:  o_entry.op = ssd_pkg::CMD_SCAN;
            default: begin
                o_entry.op = ssd_pkg::CMD_SCAN;
                o_push_ok  = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/core/ssd_queue.sv
// Short queue between front and back end holding classified words.
// Depends on ssd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ssd_queue (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_push,
    input  wire ssd_pkg::t_queue_entry i_entry,
    output logic                       o_full,
    output logic                       o_nonempty,
    input  wire                        i_pop,
    output ssd_pkg::t_queue_entry      o_entry
);

    localparam logic [ssd_pkg::QCNT_W-1:0] DEPTH_CNT = ssd_pkg::QCNT_W'(ssd_pkg::QUEUE_DEPTH);
    localparam logic [ssd_pkg::QPTR_W-1:0] LAST_PTR  = ssd_pkg::QPTR_W'(ssd_pkg::QUEUE_DEPTH - 1);

    ssd_pkg::t_queue_entry          r_mem [ssd_pkg::QUEUE_DEPTH];
    logic [ssd_pkg::QPTR_W-1:0]     r_wr_ptr, n_wr_ptr;
    logic [ssd_pkg::QPTR_W-1:0]     r_rd_ptr, n_rd_ptr;
    logic [ssd_pkg::QCNT_W-1:0]     r_count,  n_count;

    assign o_full     = (r_count == DEPTH_CNT);
    assign o_nonempty = (r_count != '0);
    assign o_entry    = r_mem[r_rd_ptr];

    // Advance pointers and count
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Write storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/ssd_back.sv
// Back end: holds the digit store and scan index, executes queued words and
// drives the registered result word. Depends on ssd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ssd_back (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_nonempty,
    input  wire ssd_pkg::t_queue_entry i_entry,
    output logic                       o_pop,
    output logic                       o_out_valid,
    input  wire                        i_out_ready,
    output ssd_pkg::t_out_word         o_out_data
);

    localparam logic [ssd_pkg::IDX_W-1:0] LAST_IDX = ssd_pkg::IDX_W'(ssd_pkg::NUM_DIGITS - 1);

    logic [ssd_pkg::NUM_DIGITS-1:0][3:0]    r_store, n_store;
    logic [ssd_pkg::IDX_W-1:0]              r_scan_idx, n_scan_idx;
    logic                                   r_out_valid, n_out_valid;
    ssd_pkg::t_out_word                     r_out_data, n_out_data;
    logic                                   out_free;
    logic [3:0]                             code;

    assign out_free    = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign code        = r_store[r_scan_idx];

    // Execute the head word; a scan waits for a free output register
    always_comb begin
        n_store     = r_store;
        n_scan_idx  = r_scan_idx;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_data  = r_out_data;
        o_pop       = 1'b0;
        if (i_nonempty) begin
            unique case (i_entry.op)
                ssd_pkg::CMD_LOAD: begin
                    o_pop   = 1'b1;
                    n_store = i_entry.digits;
                end
                ssd_pkg::CMD_CLEAR: begin
                    o_pop = 1'b1;
                    for (int i = 0; i < ssd_pkg::NUM_DIGITS; i++) begin
                        n_store[i] = ssd_pkg::BLANK_CODE;
                    end
                end
                ssd_pkg::CMD_SCAN: begin
                    if (out_free) begin
                        o_pop       = 1'b1;
                        n_out_valid = 1'b1;
                        n_out_data.segment_pattern =
                            (code < 4'd10) ? ssd_pkg::SEG_TABLE[code] : 7'h00;
                        n_out_data.digit_select_n  = ~(4'b0001 << r_scan_idx);
                        n_out_data.decimal_point   =
                            (r_scan_idx == ssd_pkg::IDX_W'(1));
                        n_out_data.digit_index     = 2'(r_scan_idx);
                        n_scan_idx = (r_scan_idx == LAST_IDX) ? '0 : r_scan_idx + 1'b1;
                    end
                end
                default: begin
                    o_pop = 1'b1;
                end
            endcase
        end
    end

    // Hold state; reset shows 0.0 with upper digits blank
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < ssd_pkg::NUM_DIGITS; i++) begin
                r_store[i] <= (i < 2) ? ssd_pkg::ZERO_CODE : ssd_pkg::BLANK_CODE;
            end
            r_scan_idx  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_store     <= n_store;
            r_scan_idx  <= n_scan_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data <= n_out_data;
    end

endmodule

`default_nettype wire

// File: rtl/core/seven_segment_speed_display.sv
// Seven-segment speed display, top level. A command is accepted whenever the
// queue is not full; a scan tick's result word passes the two-entry queue and
// the output register, one word per cycle sustained while the output is ready.
// Loads and clears give no word. Synchronous active-low reset shows 0.0 with
// digits 2 and up blank, scans from digit 0 and empties the queue.
`timescale 1ns / 1ps
`default_nettype none

module seven_segment_speed_display (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_in_valid,
    output logic                   o_in_ready,
    input  wire ssd_pkg::t_in_word i_in_data,
    output logic                   o_out_valid,
    input  wire                    i_out_ready,
    output ssd_pkg::t_out_word     o_out_data
);

    ssd_pkg::t_queue_entry  front_entry;
    ssd_pkg::t_queue_entry  head_entry;
    logic                   push_ok;
    logic                   q_full;
    logic                   q_nonempty;
    logic                   q_pop;

    assign o_in_ready = !q_full;

    // Classify and split input words
    ssd_front u_front (
        .i_word    (i_in_data),
        .o_entry   (front_entry),
        .o_push_ok (push_ok)
    );

    // Decouple front from back
    ssd_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (i_in_valid && !q_full && push_ok),
        .i_entry    (front_entry),
        .o_full     (q_full),
        .o_nonempty (q_nonempty),
        .i_pop      (q_pop),
        .o_entry    (head_entry)
    );

    // Execute and drive results
    ssd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_nonempty  (q_nonempty),
        .i_entry     (head_entry),
        .o_pop       (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire
